@@ design/fpht_pkg.sv @@
// ----------------------------------------------------------------------------
// fpht_pkg
// Shared types and constants for the frame-stamped pair hash table.
// ----------------------------------------------------------------------------
package fpht_pkg;

  // operation codes
  localparam logic [1:0] OP_BEGIN  = 2'd0;
  localparam logic [1:0] OP_FIND   = 2'd1;
  localparam logic [1:0] OP_UPDATE = 2'd2;
  localparam logic [1:0] OP_END    = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // hash constants, 64-bit multipliers split into 32-bit halves
  localparam logic [31:0] C1_LO  = 32'h7F4A7C15;
  localparam logic [31:0] C1_HI  = 32'h9E3779B9;
  localparam logic [63:0] ADD_K  = 64'h0000_0000_7F4A_7C15;
  localparam logic [31:0] C2_LO  = 32'h1CE4E5B9;
  localparam logic [31:0] C2_HI  = 32'hBF58476D;
  localparam int unsigned SHIFT1 = 29;

  // widest home slot index the table supports
  localparam int unsigned HASH_W = 16;

  localparam logic [7:0] CAP_RESET = 8'd128;

  // item passed from the front to the back
  typedef struct packed {
    logic [1:0]        operation;
    logic [31:0]       body_a;
    logic [31:0]       body_b;
    logic [63:0]       payload;
    logic [HASH_W-1:0] home;
  } item_t;

  // one table slot as held in memory; home kept for the rebuild
  typedef struct packed {
    logic [HASH_W-1:0] home;
    logic [31:0]       key_a;
    logic [31:0]       key_b;
    logic [31:0]       stamp;
    logic [63:0]       payload;
  } slot_t;

endpackage

@@ design/fpht_ram.sv @@
// ----------------------------------------------------------------------------
// fpht_ram
// Generic single-port RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module fpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ design/fpht_front.sv @@
// ----------------------------------------------------------------------------
// fpht_front
// Accepts words and computes the pair hash home slot with one shared
// 32x32 multiplier, then pushes the classified word into the queue.
// ----------------------------------------------------------------------------
module fpht_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          operation,
  input  logic [31:0]         body_a,
  input  logic [31:0]         body_b,
  input  logic [63:0]         payload,
  input  logic                hold,
  output logic                push,
  output fpht_pkg::item_t     push_item,
  input  logic                full
);

  localparam logic [2:0] S_M0   = 3'd0;
  localparam logic [2:0] S_M1   = 3'd1;
  localparam logic [2:0] S_MIX  = 3'd2;
  localparam logic [2:0] S_M2   = 3'd3;
  localparam logic [2:0] S_M3   = 3'd4;
  localparam logic [2:0] S_M4   = 3'd5;
  localparam logic [2:0] S_PUSH = 3'd6;

  logic        busy;
  logic [2:0]  step;
  logic [1:0]  op;
  logic [31:0] ka;
  logic [31:0] kb;
  logic [63:0] pl;
  logic [63:0] acc;
  logic [63:0] prod;
  logic [31:0] ma;
  logic [31:0] mb;
  logic [63:0] m;
  logic [63:0] mix;
  logic        accept;

  assign in_stall = busy | hold;
  assign accept   = in_valid & ~in_stall;

  // shared multiplier operand select
  always_comb begin
    unique case (step)
      S_M0:    begin ma = ka;         mb = fpht_pkg::C1_LO; end
      S_M1:    begin ma = ka;         mb = fpht_pkg::C1_HI; end
      S_M2:    begin ma = acc[31:0];  mb = fpht_pkg::C2_LO; end
      S_M3:    begin ma = acc[31:0];  mb = fpht_pkg::C2_HI; end
      S_M4:    begin ma = acc[63:32]; mb = fpht_pkg::C2_LO; end
      default: begin ma = '0;         mb = '0;              end
    endcase
  end

  assign m = {32'd0, ma} * {32'd0, mb};

  // xor with offset second id, then xorshift
  always_comb begin
    logic [63:0] x;
    x   = acc ^ ({32'd0, kb} + fpht_pkg::ADD_K);
    mix = x ^ (x >> fpht_pkg::SHIFT1);
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= S_M0;
    end else if (accept) begin
      busy <= 1'b1;
      step <= S_M0;
    end else if (busy) begin
      if (step == S_PUSH) begin
        if (!full) begin
          busy <= 1'b0;
        end
      end else begin
        step <= step + 3'd1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      op <= operation;
      ka <= body_a;
      kb <= body_b;
      pl <= payload;
    end
    case (step)
      S_M0:    acc <= m;
      S_M1:    acc[63:32] <= acc[63:32] + m[31:0];
      S_MIX:   acc <= mix;
      S_M2:    prod <= m;
      S_M3:    prod[63:32] <= prod[63:32] + m[31:0];
      S_M4:    prod[63:32] <= prod[63:32] + m[31:0];
      default: ;
    endcase
  end

  assign push                = busy & (step == S_PUSH);
  assign push_item.operation = op;
  assign push_item.body_a    = ka;
  assign push_item.body_b    = kb;
  assign push_item.payload   = pl;
  // final h ^= h >> 32, low bits only
  assign push_item.home      = prod[fpht_pkg::HASH_W-1:0] ^
                               prod[32 +: fpht_pkg::HASH_W];

endmodule

@@ design/fpht_queue.sv @@
// ----------------------------------------------------------------------------
// fpht_queue
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module fpht_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  fpht_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output fpht_pkg::item_t pop_item,
  output logic            empty
);

  fpht_pkg::item_t ent [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;
  logic            do_push;
  logic            do_pop;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign do_push  = push & ~full;
  assign do_pop   = pop & ~empty;
  assign pop_item = ent[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent[wr_ptr] <= push_item;
    end
  end

endmodule

@@ design/fpht_back.sv @@
// ----------------------------------------------------------------------------
// fpht_back
// Table sequencer: probes, inserts and updates slots, rebuilds the spare
// bank at end of frame, and holds the result register.
// ----------------------------------------------------------------------------
module fpht_back #(
  parameter int TABLE_SLOTS = 256
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_write_enable,
  input  logic [7:0]      cfg_write_data,
  input  logic            q_empty,
  input  fpht_pkg::item_t q_item,
  output logic            q_pop,
  output logic            clearing,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [1:0]      status,
  output logic [63:0]     payload_out,
  output logic [7:0]      live_count
);

  localparam int SLOT_W = $clog2(TABLE_SLOTS);
  localparam int WORD_W = $bits(fpht_pkg::slot_t);

  localparam logic [2:0] B_CLEAR  = 3'd0;
  localparam logic [2:0] B_IDLE   = 3'd1;
  localparam logic [2:0] B_LOOK   = 3'd2;
  localparam logic [2:0] B_ECLR   = 3'd3;
  localparam logic [2:0] B_ESCAN  = 3'd4;
  localparam logic [2:0] B_EEXAM  = 3'd5;
  localparam logic [2:0] B_EPROBE = 3'd6;

  localparam logic [SLOT_W-1:0] SLOT_ONE = {{(SLOT_W-1){1'b0}}, 1'b1};
  localparam logic [SLOT_W:0]   IDX_ONE  = {{SLOT_W{1'b0}}, 1'b1};

  logic [2:0]        state, state_next;
  logic [SLOT_W:0]   idx, idx_next;
  logic [SLOT_W-1:0] slot, slot_next;
  logic [SLOT_W-1:0] pcount, pcount_next;
  logic [31:0]       frame, frame_next;
  logic [7:0]        occ, occ_next;
  logic [7:0]        kept, kept_next;
  logic              bank, bank_next;
  logic [7:0]        capacity;
  fpht_pkg::item_t   cur;
  fpht_pkg::slot_t   ent;
  logic              ent_load;

  logic              ram_we;
  logic [SLOT_W:0]   ram_addr;
  fpht_pkg::slot_t   ram_wdata;
  logic [WORD_W-1:0] ram_rdata;
  fpht_pkg::slot_t   rd;

  logic              res_load;
  logic [1:0]        res_status;
  logic [63:0]       res_payload;
  logic [7:0]        res_count;

  logic              out_free;
  logic              slot_empty;
  logic              hit;
  logic              probe_last;
  logic              is_find;
  logic [SLOT_W-1:0] q_home;
  logic [SLOT_W-1:0] rd_home;
  logic [31:0]       frame_inc;
  fpht_pkg::slot_t   new_entry;

  fpht_ram #(
    .WIDTH (WORD_W),
    .DEPTH (2 * TABLE_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign rd         = fpht_pkg::slot_t'(ram_rdata);
  assign out_free   = ~out_valid | ~out_stall;
  assign slot_empty = (rd.stamp == 32'd0);
  assign hit        = ~slot_empty & (rd.key_a == cur.body_a) & (rd.key_b == cur.body_b);
  assign probe_last = (pcount == {SLOT_W{1'b1}});
  assign is_find    = (cur.operation == fpht_pkg::OP_FIND);
  assign q_home     = q_item.home[SLOT_W-1:0];
  assign rd_home    = rd.home[SLOT_W-1:0];
  assign frame_inc  = frame + 32'd1;
  assign q_pop      = (state == B_IDLE) & ~q_empty & out_free;
  assign clearing   = (state == B_CLEAR);

  assign new_entry.home    = cur.home;
  assign new_entry.key_a   = cur.body_a;
  assign new_entry.key_b   = cur.body_b;
  assign new_entry.stamp   = frame;
  assign new_entry.payload = cur.payload;

  // sequencer
  always_comb begin
    logic              advance;
    logic [7:0]        kept_adv;
    state_next  = state;
    idx_next    = idx;
    slot_next   = slot;
    pcount_next = pcount;
    frame_next  = frame;
    occ_next    = occ;
    kept_next   = kept;
    bank_next   = bank;
    ent_load    = 1'b0;
    ram_we      = 1'b0;
    ram_addr    = '0;
    ram_wdata   = '0;
    res_load    = 1'b0;
    res_status  = fpht_pkg::ST_OK;
    res_payload = 64'd0;
    res_count   = occ;
    advance     = 1'b0;
    kept_adv    = kept;

    unique case (state)
      // wipe both banks after reset
      B_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = idx;
        idx_next = idx + IDX_ONE;
        if (idx == {(SLOT_W+1){1'b1}}) begin
          state_next = B_IDLE;
        end
      end

      B_IDLE: begin
        if (q_pop) begin
          unique case (q_item.operation) inside
            fpht_pkg::OP_BEGIN: begin
              frame_next = (frame_inc == 32'd0) ? 32'd1 : frame_inc;
              res_load   = 1'b1;
            end
            fpht_pkg::OP_FIND, fpht_pkg::OP_UPDATE: begin
              ram_addr    = {bank, q_home};
              slot_next   = q_home;
              pcount_next = '0;
              state_next  = B_LOOK;
            end
            default: begin
              idx_next   = '0;
              state_next = B_ECLR;
            end
          endcase
        end
      end

      // examine the slot read last cycle, issue the next probe
      B_LOOK: begin
        if (slot_empty) begin
          state_next = B_IDLE;
          res_load   = 1'b1;
          if (is_find) begin
            res_status = fpht_pkg::ST_MISS;
          end else if (occ >= capacity) begin
            res_status = fpht_pkg::ST_FULL;
          end else begin
            ram_we      = 1'b1;
            ram_addr    = {bank, slot};
            ram_wdata   = new_entry;
            occ_next    = occ + 8'd1;
            res_payload = cur.payload;
            res_count   = occ + 8'd1;
          end
        end else if (hit) begin
          state_next = B_IDLE;
          res_load   = 1'b1;
          if (is_find) begin
            res_payload = rd.payload;
          end else begin
            ram_we      = 1'b1;
            ram_addr    = {bank, slot};
            ram_wdata   = new_entry;
            res_payload = cur.payload;
          end
        end else if (probe_last) begin
          state_next = B_IDLE;
          res_load   = 1'b1;
          res_status = is_find ? fpht_pkg::ST_MISS : fpht_pkg::ST_FULL;
        end else begin
          slot_next   = slot + SLOT_ONE;
          pcount_next = pcount + SLOT_ONE;
          ram_addr    = {bank, slot + SLOT_ONE};
        end
      end

      // clear the spare bank
      B_ECLR: begin
        ram_we   = 1'b1;
        ram_addr = {~bank, idx[SLOT_W-1:0]};
        idx_next = idx + IDX_ONE;
        if (idx[SLOT_W-1:0] == {SLOT_W{1'b1}}) begin
          idx_next   = '0;
          kept_next  = 8'd0;
          state_next = B_ESCAN;
        end
      end

      B_ESCAN: begin
        ram_addr   = {bank, idx[SLOT_W-1:0]};
        state_next = B_EEXAM;
      end

      // keep entries stamped this frame
      B_EEXAM: begin
        if (!slot_empty && rd.stamp == frame) begin
          ent_load    = 1'b1;
          slot_next   = rd_home;
          pcount_next = '0;
          ram_addr    = {~bank, rd_home};
          state_next  = B_EPROBE;
        end else begin
          advance = 1'b1;
        end
      end

      // find a free slot in the spare bank
      B_EPROBE: begin
        if (slot_empty) begin
          ram_we    = 1'b1;
          ram_addr  = {~bank, slot};
          ram_wdata = ent;
          kept_adv  = kept + 8'd1;
          advance   = 1'b1;
        end else if (probe_last) begin
          advance = 1'b1;
        end else begin
          slot_next   = slot + SLOT_ONE;
          pcount_next = pcount + SLOT_ONE;
          ram_addr    = {~bank, slot + SLOT_ONE};
        end
      end

      default: begin
        state_next = B_IDLE;
      end
    endcase

    // next source slot, or finish the rebuild
    if (advance) begin
      kept_next = kept_adv;
      if (idx[SLOT_W-1:0] == {SLOT_W{1'b1}}) begin
        occ_next   = kept_adv;
        bank_next  = ~bank;
        res_load   = 1'b1;
        res_count  = kept_adv;
        state_next = B_IDLE;
      end else begin
        idx_next   = idx + IDX_ONE;
        state_next = B_ESCAN;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_CLEAR;
      idx       <= '0;
      frame     <= 32'd0;
      occ       <= 8'd0;
      kept      <= 8'd0;
      bank      <= 1'b0;
      capacity  <= fpht_pkg::CAP_RESET;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      frame <= frame_next;
      occ   <= occ_next;
      kept  <= kept_next;
      bank  <= bank_next;
      if (cfg_write_enable) begin
        capacity <= cfg_write_data;
      end
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    slot   <= slot_next;
    pcount <= pcount_next;
    if (q_pop) begin
      cur <= q_item;
    end
    if (ent_load) begin
      ent <= rd;
    end
    if (res_load) begin
      status      <= res_status;
      payload_out <= res_payload;
      live_count  <= res_count;
    end
  end

`ifndef ASSERT_OFF
  // memory is never written while waiting for work
  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == B_IDLE) |-> !ram_we)
    else $error("table written while idle");

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_load |-> (!out_valid || !out_stall))
    else $error("result register overwritten");

  // a lookup writes only an empty or matching slot
  a_write_target: assert property (@(posedge clk) disable iff (rst)
    (state == B_LOOK && ram_we) |-> (slot_empty || hit))
    else $error("lookup wrote an occupied foreign slot");

  // no word leaves the queue during the clearing pass
  a_clear_no_pop: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !q_pop)
    else $error("word taken during clearing pass");
`endif

endmodule

@@ design/frame_stamped_pair_hash_table_unit.sv @@
// ----------------------------------------------------------------------------
// frame_stamped_pair_hash_table_unit
// Hash table keyed by a pair of body ids, linear probing, frame stamps,
// two banks swapped by an end-of-frame rebuild.
//
//   channel | signals                                 | direction
//   --------+-----------------------------------------+----------
//   in      | in_valid, in_stall, operation, body_a,  | to block
//           | body_b, payload                         |
//   out     | out_valid, out_stall, status,           | from block
//           | payload_out, live_count                 |
//   cfg     | cfg_write_enable, cfg_write_data        | to block
//
// The front takes a new word only once the last one is pushed: five
// steps on one 32x32 multiplier build the home slot. Find and update do
// one single-port table memory read per probe in the back; end frame
// clears the spare bank and rehashes this frame's entries into it. After
// reset a clearing pass over both banks runs with in_stall high. A two-
// word queue lets the front hash while the back is busy or out is stalled.
// ----------------------------------------------------------------------------
module frame_stamped_pair_hash_table_unit #(
  parameter int TABLE_SLOTS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_enable,
  input  logic [7:0]  cfg_write_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [31:0] body_a,
  input  logic [31:0] body_b,
  input  logic [63:0] payload,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [63:0] payload_out,
  output logic [7:0]  live_count
);

  logic            push;
  logic            full;
  logic            pop;
  logic            empty;
  logic            clearing;
  fpht_pkg::item_t push_item;
  fpht_pkg::item_t pop_item;

  // hash front end
  fpht_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .body_a    (body_a),
    .body_b    (body_b),
    .payload   (payload),
    .hold      (clearing),
    .push      (push),
    .push_item (push_item),
    .full      (full)
  );

  fpht_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .pop_item  (pop_item),
    .empty     (empty)
  );

  // table sequencer
  fpht_back #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data),
    .q_empty          (empty),
    .q_item           (pop_item),
    .q_pop            (pop),
    .clearing         (clearing),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .status           (status),
    .payload_out      (payload_out),
    .live_count       (live_count)
  );

endmodule
